@@ src/lpmf_pkg.sv @@
`default_nettype none

package lpmf_pkg;

    localparam int KIND_W     = 2;
    localparam int ROW_W      = 6;
    localparam int COL_W      = 10;
    localparam int COORD_W    = 18;
    localparam int RANGE_W    = 17;
    localparam int LAYER_W    = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;
    localparam int IN_DATA_W  = 128;
    localparam int OUT_DATA_W = 8;

    typedef enum logic [KIND_W-1:0] {
        KIND_FILTER = 2'd0,
        KIND_LEARN  = 2'd1,
        KIND_CLEAR  = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        REASON_NONE   = 2'd0,
        REASON_LAYER  = 2'd1,
        REASON_CLOSE  = 2'd2,
        REASON_MASKED = 2'd3
    } reason_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RANGE,
        ST_LREAD,
        ST_LWRITE,
        ST_FINISH
    } state_t;

    localparam logic [CFG_IDX_W-1:0] CFG_BOX_X_FIRST  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_X_SECOND = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_Y_FIRST  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_Y_SECOND = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_Z_FIRST  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_Z_SECOND = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_RANGE    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_LAYER_BOUNDS = 3'd7;

    localparam logic [LAYER_W-1:0] LAYER_RESET = 16'hFF00;

endpackage

`default_nettype wire

@@ src/lpmf_range_sq.sv @@
`default_nettype none

// Squared range test on one shared 18x18 squarer: x^2, y^2, z^2, min^2 in
// turn, then sum < min^2. done pulses on the last step, with too_close valid.
module lpmf_range_sq
    import lpmf_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic signed [COORD_W-1:0] x,
    input  wire logic signed [COORD_W-1:0] y,
    input  wire logic signed [COORD_W-1:0] z,
    input  wire logic        [RANGE_W-1:0] floor_mm,
    output logic                           done,
    output logic                           too_close
);

    localparam int SQ_W  = 2 * COORD_W;
    localparam int PR_W  = SQ_W - 1;
    localparam int ACC_W = SQ_W + 1;
    localparam logic [2:0] LAST_STEP = 3'd4;

    logic                     run_reg, run_next;
    logic [2:0]               cnt_reg, cnt_next;
    logic signed [COORD_W-1:0] opnd;
    logic signed [SQ_W-1:0]   sq;
    logic [PR_W-1:0]          prod_reg;
    logic [ACC_W-1:0]         acc_reg, acc_next;

    always_comb
    begin
        case (cnt_reg)
            3'd0:    opnd = x;
            3'd1:    opnd = y;
            3'd2:    opnd = z;
            3'd3:    opnd = $signed({1'b0, floor_mm});
            default: opnd = x;
        endcase
        sq = opnd * opnd;
    end

    always_comb
    begin
        case (cnt_reg)
            3'd1:          acc_next = {2'b00, prod_reg};
            3'd2, 3'd3:    acc_next = acc_reg + {2'b00, prod_reg};
            default:       acc_next = acc_reg;
        endcase
    end

    assign done      = run_reg && (cnt_reg == LAST_STEP);
    assign too_close = acc_reg < {2'b00, prod_reg};

    always_comb
    begin
        run_next = run_reg;
        cnt_next = cnt_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = 3'd0;
        end
        else if (run_reg)
        begin
            cnt_next = cnt_reg + 3'd1;
            if (cnt_reg == LAST_STEP)
            begin
                run_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            cnt_reg <= 3'd0;
        end
        else
        begin
            run_reg <= run_next;
            cnt_reg <= cnt_next;
        end
    end

    // squares are never negative, so the top product bit is always zero
    always_ff @(posedge clk)
    begin
        if (run_reg)
        begin
            prod_reg <= sq[PR_W-1:0];
            acc_reg  <= acc_next;
        end
    end

endmodule

`default_nettype wire

@@ src/lpmf_mask_mem.sv @@
`default_nettype none

// Row-wide mask memory. A row that has not been written since reset or the
// last clear reads as all zero through its valid bit.
module lpmf_mask_mem #(
    parameter  int DEPTH = 64,
    parameter  int WIDTH = 1024,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             clear,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data
);

    logic [WIDTH-1:0] mem_array [DEPTH];
    logic [WIDTH-1:0] rd_word_reg;
    logic             rd_valid_reg;
    logic [DEPTH-1:0] row_valid_reg, row_valid_next;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_array[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_word_reg <= mem_array[rd_addr];
        end
    end

    always_comb
    begin
        row_valid_next = row_valid_reg;
        if (clear)
        begin
            row_valid_next = '0;
        end
        else if (wr_en)
        begin
            row_valid_next[wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            row_valid_reg <= row_valid_next;
            if (rd_en)
            begin
                rd_valid_reg <= row_valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_word_reg : '0;

endmodule

`default_nettype wire

@@ src/lidar_point_mask_filter.sv @@
// Filter, clear and unknown requests pass accept, 5 range steps on the shared
// squarer and a decide state that loads the output register once it is free;
// learn requests that mark the mask add one read and one write of the
// row-wide mask memory per row. A new request is taken only in idle.
// Reset is asynchronous, active low; the mask reads clear through per-row
// valid bits, so there is no clearing pass and a clear request adds no time.
`default_nettype none

module lidar_point_mask_filter
    import lpmf_pkg::*;
#(
    parameter int ROWS          = 64,
    parameter int COLS          = 1024,
    parameter int DILATE_RADIUS = 2
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // row, col, point_valid, sensor_x, sensor_y, sensor_z, base_x, base_y, base_z
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    // kind
    input  wire logic [KIND_W-1:0]     s_axis_tuser,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // kept, drop_reason, in_box
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CW   = (COLS > 1) ? $clog2(COLS) : 1;
    localparam int SPAN = 2 * DILATE_RADIUS + 1;
    localparam int LCW  = (SPAN > 1) ? $clog2(SPAN) : 1;
    localparam int BW   = COLS + 2 * DILATE_RADIUS;

    function automatic logic axis_in(input logic signed [COORD_W-1:0] v,
                                     input logic signed [COORD_W-1:0] a,
                                     input logic signed [COORD_W-1:0] b);
        logic signed [COORD_W-1:0] lo;
        logic signed [COORD_W-1:0] hi;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        return (v >= lo) && (v <= hi);
    endfunction

    // configuration
    logic signed [COORD_W-1:0] box_x_first_reg, box_x_second_reg;
    logic signed [COORD_W-1:0] box_y_first_reg, box_y_second_reg;
    logic signed [COORD_W-1:0] box_z_first_reg, box_z_second_reg;
    logic        [RANGE_W-1:0] range_floor_reg;
    logic        [LAYER_W-1:0] layer_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_x_first_reg  <= '0;
            box_x_second_reg <= '0;
            box_y_first_reg  <= '0;
            box_y_second_reg <= '0;
            box_z_first_reg  <= '0;
            box_z_second_reg <= '0;
            range_floor_reg  <= '0;
            layer_reg        <= LAYER_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_BOX_X_FIRST:  box_x_first_reg  <= cfg_data;
                CFG_BOX_X_SECOND: box_x_second_reg <= cfg_data;
                CFG_BOX_Y_FIRST:  box_y_first_reg  <= cfg_data;
                CFG_BOX_Y_SECOND: box_y_second_reg <= cfg_data;
                CFG_BOX_Z_FIRST:  box_z_first_reg  <= cfg_data;
                CFG_BOX_Z_SECOND: box_z_second_reg <= cfg_data;
                CFG_MIN_RANGE:    range_floor_reg  <= cfg_data[RANGE_W-1:0];
                CFG_LAYER_BOUNDS: layer_reg        <= cfg_data[LAYER_W-1:0];
                default:          ;
            endcase
        end
    end

    // control
    state_t state_reg, state_next;
    logic   in_accept;
    logic   range_done;
    logic   range_close;
    logic   learn_go;
    logic   out_free;
    logic   out_load;
    logic   mem_rd_en;
    logic   mem_wr_en;
    logic   mem_clear;
    logic   lcnt_step;

    // latched request
    logic [KIND_W-1:0]         kind_reg;
    logic [ROW_W-1:0]          row_reg;
    logic [COL_W-1:0]          col_reg;
    logic                      valid_reg;
    logic signed [COORD_W-1:0] sx_reg, sy_reg, sz_reg;
    logic signed [COORD_W-1:0] bx_reg, by_reg, bz_reg;

    logic                      close_reg;
    logic                      inbox_reg;
    logic [LCW-1:0]            lcnt_reg;
    logic [COLS-1:0]           band_reg;

    assign in_accept = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            kind_reg  <= s_axis_tuser;
            row_reg   <= s_axis_tdata[5:0];
            col_reg   <= s_axis_tdata[15:6];
            valid_reg <= s_axis_tdata[16];
            sx_reg    <= s_axis_tdata[34:17];
            sy_reg    <= s_axis_tdata[52:35];
            sz_reg    <= s_axis_tdata[70:53];
            bx_reg    <= s_axis_tdata[88:71];
            by_reg    <= s_axis_tdata[106:89];
            bz_reg    <= s_axis_tdata[124:107];
        end
    end

    lpmf_range_sq u_range (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (in_accept),
        .x         (sx_reg),
        .y         (sy_reg),
        .z         (sz_reg),
        .floor_mm  (range_floor_reg),
        .done      (range_done),
        .too_close (range_close)
    );

    // grid checks on the latched cell
    logic          row_in, col_in, box_ok;
    logic [RW-1:0] row_addr;
    logic [CW-1:0] col_idx;

    assign row_in   = int'(row_reg) < ROWS;
    assign col_in   = int'(col_reg) < COLS;
    assign row_addr = RW'(row_reg);
    assign col_idx  = CW'(col_reg);
    assign box_ok   = axis_in(bx_reg, box_x_first_reg, box_x_second_reg) &&
                      axis_in(by_reg, box_y_first_reg, box_y_second_reg) &&
                      axis_in(bz_reg, box_z_first_reg, box_z_second_reg);
    assign learn_go = (kind_reg == KIND_LEARN) && valid_reg && row_in && col_in &&
                      !range_close && box_ok;

    // neighborhood row being marked: row - R + lcnt, may fall off the grid
    logic [10:0]   lrow;
    logic          lrow_ok;
    logic [RW-1:0] lrow_addr;

    assign lrow      = 11'(row_reg) + 11'(lcnt_reg) - 11'(DILATE_RADIUS);
    assign lrow_ok   = !lrow[10] && (int'(lrow[9:0]) < ROWS);
    assign lrow_addr = lrow[RW-1:0];

    // columns col-R .. col+R, clipped at both edges by the slice
    logic [BW-1:0] band_ext;
    assign band_ext = BW'({SPAN{1'b1}}) << col_reg;

    // mask memory
    logic [COLS-1:0] mem_rd_data;
    logic [RW-1:0]   mem_rd_addr;

    assign mem_rd_addr = (state_reg == ST_LREAD) ? lrow_addr : row_addr;

    lpmf_mask_mem #(
        .DEPTH (ROWS),
        .WIDTH (COLS)
    ) u_mask (
        .clk     (clk),
        .rst_n   (rst_n),
        .clear   (mem_clear),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data),
        .wr_en   (mem_wr_en),
        .wr_addr (lrow_addr),
        .wr_data (mem_rd_data | band_reg)
    );

    // state machine
    assign out_free = !m_axis_tvalid || m_axis_tready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = ST_RANGE;
                end
            end
            ST_RANGE:
            begin
                if (range_done)
                begin
                    state_next = learn_go ? ST_LREAD : ST_FINISH;
                end
            end
            ST_LREAD:
            begin
                state_next = ST_LWRITE;
            end
            ST_LWRITE:
            begin
                if (lcnt_reg == LCW'(SPAN - 1))
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    state_next = ST_LREAD;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_axis_tready = 1'b0;
        mem_rd_en     = 1'b0;
        mem_wr_en     = 1'b0;
        mem_clear     = 1'b0;
        lcnt_step     = 1'b0;
        out_load      = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                mem_clear     = in_accept && (s_axis_tuser == KIND_CLEAR);
            end
            ST_RANGE:
            begin
                mem_rd_en = row_in;
            end
            ST_LREAD:
            begin
                mem_rd_en = lrow_ok;
            end
            ST_LWRITE:
            begin
                mem_wr_en = lrow_ok;
                lcnt_step = 1'b1;
            end
            ST_FINISH:
            begin
                out_load = out_free;
            end
            default:
            begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            lcnt_reg  <= '0;
            inbox_reg <= 1'b0;
        end
        else
        begin
            if (lcnt_step)
            begin
                lcnt_reg <= lcnt_reg + LCW'(1);
            end
            if (range_done)
            begin
                close_reg <= range_close;
                inbox_reg <= learn_go;
            end
        end
        if (state_reg == ST_RANGE)
        begin
            band_reg <= band_ext[DILATE_RADIUS +: COLS];
        end
    end

    // kept rows from the layer window, counted from the top
    logic        [7:0] layer_low, layer_high;
    logic signed [9:0] lo_raw, hi_raw, lo_row, hi_row, row_s;
    logic              layer_out;

    always_comb
    begin
        layer_low  = layer_reg[7:0];
        layer_high = layer_reg[15:8];
        lo_raw     = 10'(ROWS - 1) - {2'b00, layer_high};
        hi_raw     = 10'(ROWS - 1) - {2'b00, layer_low};
        lo_row     = lo_raw[9] ? 10'sd0 : lo_raw;
        hi_row     = hi_raw[9] ? 10'sd0 : hi_raw;
        row_s      = $signed({4'b0000, row_reg});
        layer_out  = (row_s < lo_row) || (row_s > hi_row) || !row_in;
    end

    // result
    reason_t reason;
    logic    res_kept, res_inbox;

    always_comb
    begin
        reason    = REASON_NONE;
        res_kept  = 1'b0;
        res_inbox = 1'b0;
        case (kind_reg)
            KIND_FILTER:
            begin
                if (layer_out)
                begin
                    reason = REASON_LAYER;
                end
                else if (valid_reg && close_reg)
                begin
                    reason = REASON_CLOSE;
                end
                else if (col_in && mem_rd_data[col_idx])
                begin
                    reason = REASON_MASKED;
                end
                res_kept = (reason == REASON_NONE);
            end
            KIND_LEARN:
            begin
                res_inbox = inbox_reg;
            end
            default:
            begin
                res_kept = 1'b0;
            end
        endcase
    end

    logic       out_valid_reg, out_valid_next;
    logic       out_kept_reg, out_inbox_reg;
    logic [1:0] out_reason_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_kept_reg   <= res_kept;
            out_reason_reg <= reason;
            out_inbox_reg  <= res_inbox;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0000, out_inbox_reg, out_reason_reg, out_kept_reg};

endmodule

`default_nettype wire

@@ tb/lidar_point_mask_filter_test.sv @@
`default_nettype none

module lidar_point_mask_filter_test
    import lpmf_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int GRID_ROWS    = 64;
    localparam int GRID_COLS    = 1024;
    localparam int MARK_RADIUS  = 2;
    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 40;
    localparam int PHASE_ITEMS  = 230;
    localparam int HOLD_CYCLES  = 400;

    localparam longint COORD_MIN = -131072;
    localparam longint COORD_MAX = 131071;

    // kind code 3 has no operation
    localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;

    typedef struct {
        logic [KIND_W-1:0]         kind;
        logic [ROW_W-1:0]          row;
        logic [COL_W-1:0]          col;
        logic                      valid;
        logic signed [COORD_W-1:0] sx;
        logic signed [COORD_W-1:0] sy;
        logic signed [COORD_W-1:0] sz;
        logic signed [COORD_W-1:0] bx;
        logic signed [COORD_W-1:0] by;
        logic signed [COORD_W-1:0] bz;
    } point_req_t;

    typedef struct {
        logic    kept;
        reason_t reason;
        logic    in_box;
    } verdict_t;

    class mask_verdict_board;
        bit                 cell_mask [GRID_ROWS*GRID_COLS];
        longint             box_bound [6];
        longint             range_floor_mm;
        logic [LAYER_W-1:0] layer_win;
        verdict_t           expected_q [$];
        int                 mismatches;

        function new();
            clear_mask();
            foreach (box_bound[i])
                box_bound[i] = 0;
            range_floor_mm = 0;
            layer_win      = LAYER_RESET;
            mismatches     = 0;
        endfunction

        function void clear_mask();
            foreach (cell_mask[i])
                cell_mask[i] = 1'b0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_MIN_RANGE:    range_floor_mm = data[RANGE_W-1:0];
                CFG_LAYER_BOUNDS: layer_win = data[LAYER_W-1:0];
                default:          box_bound[idx] = longint'(signed'(data));
            endcase
        endfunction

        function int clamp_row(int v);
            if (v < 0)
                return 0;
            if (v > GRID_ROWS - 1)
                return GRID_ROWS - 1;
            return v;
        endfunction

        function bit close_point(point_req_t r);
            longint x;
            longint y;
            longint z;
            longint m;
            x = r.sx;
            y = r.sy;
            z = r.sz;
            m = range_floor_mm;
            return (x * x + y * y + z * z) < m * m;
        endfunction

        function bit axis_hit(longint v, longint a, longint b);
            return v >= (a < b ? a : b) && v <= (a > b ? a : b);
        endfunction

        function verdict_t predict_verdict(point_req_t r);
            verdict_t v;
            int lo;
            int hi;
            int rr;
            int cc;
            v.kept   = 1'b0;
            v.reason = REASON_NONE;
            v.in_box = 1'b0;
            rr = r.row;
            cc = r.col;
            case (r.kind)
                KIND_FILTER:
                begin
                    // window given from the bottom, rows counted from the top
                    lo = clamp_row(GRID_ROWS - 1 - int'(layer_win[15:8]));
                    hi = clamp_row(GRID_ROWS - 1 - int'(layer_win[7:0]));
                    if (rr < lo || rr > hi || rr >= GRID_ROWS)
                        v.reason = REASON_LAYER;
                    else if (r.valid && close_point(r))
                        v.reason = REASON_CLOSE;
                    else if (cc < GRID_COLS && cell_mask[rr*GRID_COLS + cc])
                        v.reason = REASON_MASKED;
                    v.kept = (v.reason == REASON_NONE);
                end
                KIND_LEARN:
                begin
                    if (r.valid && rr < GRID_ROWS && cc < GRID_COLS && !close_point(r)
                        && axis_hit(r.bx, box_bound[CFG_BOX_X_FIRST], box_bound[CFG_BOX_X_SECOND])
                        && axis_hit(r.by, box_bound[CFG_BOX_Y_FIRST], box_bound[CFG_BOX_Y_SECOND])
                        && axis_hit(r.bz, box_bound[CFG_BOX_Z_FIRST], box_bound[CFG_BOX_Z_SECOND]))
                    begin
                        v.in_box = 1'b1;
                        for (int dr = -MARK_RADIUS; dr <= MARK_RADIUS; dr++)
                        begin
                            for (int dc = -MARK_RADIUS; dc <= MARK_RADIUS; dc++)
                            begin
                                if (rr + dr >= 0 && rr + dr < GRID_ROWS
                                    && cc + dc >= 0 && cc + dc < GRID_COLS)
                                    cell_mask[(rr + dr)*GRID_COLS + cc + dc] = 1'b1;
                            end
                        end
                    end
                end
                KIND_CLEAR:
                    clear_mask();
                default:
                    ;
            endcase
            return v;
        endfunction

        function void note_request(point_req_t r);
            expected_q.push_back(predict_verdict(r));
        endfunction

        function void report(string field, logic [1:0] want, logic [1:0] got);
            if (got !== want)
            begin
                mismatches++;
                $display("%0t: %s mismatch: expected %0d, actual %0d",
                         $time, field, want, got);
            end
        endfunction

        function void check_verdict(logic [OUT_DATA_W-1:0] data);
            verdict_t e;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                $display("%0t: result with no request pending: expected none, actual %h",
                         $time, data);
                return;
            end
            e = expected_q.pop_front();
            report("kept", e.kept, data[0]);
            report("drop_reason", e.reason, data[2:1]);
            report("in_box", e.in_box, data[3]);
        endfunction
    endclass

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic [KIND_W-1:0]     s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [CFG_DATA_W-1:0] cfg_data      = '0;

    mask_verdict_board board = new();

    logic [CFG_DATA_W-1:0] next_regs [8];
    int tx_run      = 0;
    int rx_run      = 0;
    int rx_hold     = 0;
    int hot_row     = 0;
    int hot_col     = 0;
    int idle_cycles = 0;

    lidar_point_mask_filter #(
        .ROWS          (GRID_ROWS),
        .COLS          (GRID_COLS),
        .DILATE_RADIUS (MARK_RADIUS)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // a run of zero-gap items now and then, random gaps otherwise
    function automatic int draw_gap(inout int run);
        if (run > 0)
        begin
            run--;
            return 0;
        end
        if ($urandom_range(0, 39) == 0)
            run = 20;
        return $urandom_range(0, 13);
    endfunction

    function automatic logic [IN_DATA_W-1:0] pack_request(point_req_t r);
        return {3'b000, r.bz, r.by, r.bx, r.sz, r.sy, r.sx, r.valid, r.col, r.row};
    endfunction

    function automatic point_req_t mk_req(logic [KIND_W-1:0] kind, int row, int col,
                                          bit valid, longint sx, longint sy, longint sz,
                                          longint bx, longint by, longint bz);
        point_req_t r;
        r.kind  = kind;
        r.row   = ROW_W'(row);
        r.col   = COL_W'(col);
        r.valid = valid;
        r.sx    = COORD_W'(sx);
        r.sy    = COORD_W'(sy);
        r.sz    = COORD_W'(sz);
        r.bx    = COORD_W'(bx);
        r.by    = COORD_W'(by);
        r.bz    = COORD_W'(bz);
        return r;
    endfunction

    function automatic logic signed [COORD_W-1:0] rand_coord(longint scale);
        case ($urandom_range(0, 9))
            0:       return COORD_W'(COORD_MIN);
            1:       return COORD_W'(COORD_MAX);
            2:       return COORD_W'($urandom);
            default: return COORD_W'(longint'($urandom_range(0, 2 * scale)) - scale);
        endcase
    endfunction

    // mostly inside the box, with the bounds and one step past them
    function automatic logic signed [COORD_W-1:0] pick_axis(longint a, longint b);
        longint lo;
        longint hi;
        lo = a < b ? a : b;
        hi = a > b ? a : b;
        case ($urandom_range(0, 9))
            6:       return COORD_W'(lo);
            7:       return COORD_W'(hi);
            8:       return COORD_W'(lo > COORD_MIN ? lo - 1 : hi);
            9:       return COORD_W'(hi < COORD_MAX ? hi + 1 : longint'($urandom));
            default: return COORD_W'(lo + longint'($urandom_range(0, hi - lo)));
        endcase
    endfunction

    function automatic point_req_t random_request();
        point_req_t r;
        int pick;
        longint scale;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            r.kind = KIND_FILTER;
        else if (pick < 94)
            r.kind = KIND_LEARN;
        else if (pick < 97)
            r.kind = KIND_CLEAR;
        else
            r.kind = KIND_NONE;
        // most points land in a small patch so that learned cells get hit
        if ($urandom_range(0, 4) != 0)
        begin
            r.row = ROW_W'(hot_row + $urandom_range(0, 7));
            r.col = COL_W'(hot_col + $urandom_range(0, 15));
        end
        else
        begin
            r.row = ROW_W'($urandom);
            r.col = COL_W'($urandom);
        end
        if ($urandom_range(0, 19) == 0)
            r.row = $urandom_range(0, 1) ? ROW_W'(GRID_ROWS - 1) : '0;
        if ($urandom_range(0, 19) == 0)
            r.col = $urandom_range(0, 1) ? COL_W'(GRID_COLS - 1) : '0;
        r.valid = ($urandom_range(0, 7) != 0);
        scale = board.range_floor_mm > 64 ? board.range_floor_mm : 4000;
        r.sx = rand_coord(scale);
        r.sy = rand_coord(scale);
        r.sz = rand_coord(scale);
        if ($urandom_range(0, 14) == 0)
        begin
            r.sx = COORD_W'(board.range_floor_mm - $urandom_range(0, 1));
            r.sy = '0;
            r.sz = '0;
        end
        r.bx = pick_axis(board.box_bound[CFG_BOX_X_FIRST], board.box_bound[CFG_BOX_X_SECOND]);
        r.by = pick_axis(board.box_bound[CFG_BOX_Y_FIRST], board.box_bound[CFG_BOX_Y_SECOND]);
        r.bz = pick_axis(board.box_bound[CFG_BOX_Z_FIRST], board.box_bound[CFG_BOX_Z_SECOND]);
        return r;
    endfunction

    task automatic send_request(point_req_t r);
        int gap;
        gap = draw_gap(tx_run);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pack_request(r);
        s_axis_tuser  <= r.kind;
        do
            @(posedge clk);
        while (!s_axis_tready);
        board.note_request(r);
    endtask

    // wait for every pending verdict, then let the pipeline run empty
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (board.expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic load_phase(longint xf, longint xs, longint yf, longint ys,
                              longint zf, longint zs, longint min_mm, longint layers);
        settle();
        next_regs[CFG_BOX_X_FIRST]  = CFG_DATA_W'(xf);
        next_regs[CFG_BOX_X_SECOND] = CFG_DATA_W'(xs);
        next_regs[CFG_BOX_Y_FIRST]  = CFG_DATA_W'(yf);
        next_regs[CFG_BOX_Y_SECOND] = CFG_DATA_W'(ys);
        next_regs[CFG_BOX_Z_FIRST]  = CFG_DATA_W'(zf);
        next_regs[CFG_BOX_Z_SECOND] = CFG_DATA_W'(zs);
        next_regs[CFG_MIN_RANGE]    = CFG_DATA_W'(min_mm);
        next_regs[CFG_LAYER_BOUNDS] = CFG_DATA_W'(layers);
        for (int i = 0; i < 8; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_data  <= next_regs[i];
            board.set_reg(CFG_IDX_W'(i), next_regs[i]);
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    task automatic run_phase(int n, bit hold_rx, bit pause_mid);
        int lo_row;
        lo_row = board.clamp_row(GRID_ROWS - 1 - int'(board.layer_win[15:8]));
        hot_row = lo_row > GRID_ROWS - 8 ? GRID_ROWS - 8 : lo_row;
        case ($urandom_range(0, 2))
            0:       hot_col = 0;
            1:       hot_col = GRID_COLS - 16;
            default: hot_col = $urandom_range(0, GRID_COLS - 16);
        endcase
        if (hold_rx)
        begin
            // sink stalls while the source keeps pushing back to back
            rx_hold = HOLD_CYCLES;
            tx_run  = 60;
        end
        for (int i = 0; i < n; i++)
        begin
            if (pause_mid && i == n / 2)
                settle();
            send_request(random_request());
        end
    endtask

    initial
    begin
        int wait_n;
        @(posedge rst_n);
        forever
        begin
            if (rx_hold > 0)
            begin
                wait_n  = rx_hold;
                rx_hold = 0;
            end
            else
                wait_n = draw_gap(rx_run);
            if (wait_n > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (wait_n) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
            board.check_verdict(m_axis_tdata);
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else if (idle_cycles == IDLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // pairs at the coordinate extremes, x and z inverted: the box is everything
        load_phase(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN,
                   1000, 16'hFF00);
        send_request(mk_req(KIND_FILTER, 0, 0, 1, 0, 0, 0, 0, 0, 0));
        send_request(mk_req(KIND_FILTER, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_request(mk_req(KIND_FILTER, 63, 1023, 1, COORD_MIN, COORD_MAX, COORD_MIN,
                            COORD_MAX, COORD_MAX, COORD_MAX));
        send_request(mk_req(KIND_FILTER, 10, 10, 1, 999, 0, 0, 0, 0, 0));
        send_request(mk_req(KIND_FILTER, 10, 10, 1, 0, 0, 1000, 0, 0, 0));
        // corner learns, clipped at the grid edges
        send_request(mk_req(KIND_LEARN, 0, 0, 1, 2000, 0, 0, COORD_MAX, COORD_MIN, COORD_MAX));
        send_request(mk_req(KIND_FILTER, 2, 2, 1, 5000, 0, 0, 0, 0, 0));
        send_request(mk_req(KIND_FILTER, 3, 0, 1, 5000, 0, 0, 0, 0, 0));
        send_request(mk_req(KIND_LEARN, 63, 1023, 1, 0, -5000, 0, COORD_MIN, COORD_MAX,
                            COORD_MIN));
        send_request(mk_req(KIND_FILTER, 61, 1021, 0, 0, 0, 0, 0, 0, 0));
        send_request(mk_req(KIND_FILTER, 61, 1020, 1, 0, 4000, 0, 0, 0, 0));
        send_request(mk_req(KIND_LEARN, 30, 500, 0, 5000, 0, 0, 0, 0, 0));
        send_request(mk_req(KIND_LEARN, 30, 500, 1, 10, 10, 10, 0, 0, 0));
        send_request(mk_req(KIND_FILTER, 30, 500, 1, 5000, 0, 0, 0, 0, 0));
        send_request(mk_req(KIND_NONE, 63, 1023, 1, -1, -1, -1, -1, -1, -1));
        send_request(mk_req(KIND_CLEAR, 0, 0, 1, 0, 0, 0, 0, 0, 0));
        send_request(mk_req(KIND_FILTER, 0, 0, 1, 5000, 0, 0, 0, 0, 0));

        // tight box with inclusive bounds, window upside down
        load_phase(100, -100, 100, -100, 100, -100, 0, 16'h00FF);
        send_request(mk_req(KIND_LEARN, 31, 511, 1, 0, 0, 0, 100, -100, 0));
        send_request(mk_req(KIND_LEARN, 31, 511, 1, 0, 0, 0, 101, 0, 0));
        send_request(mk_req(KIND_FILTER, 31, 511, 1, 0, 0, 0, 0, 0, 0));

        // rows 31 to 47 only, largest minimum range
        load_phase(100, -100, 100, -100, 100, -100, COORD_MAX, 16'h2010);
        send_request(mk_req(KIND_FILTER, 30, 0, 0, 0, 0, 0, 0, 0, 0));
        send_request(mk_req(KIND_FILTER, 48, 0, 0, 0, 0, 0, 0, 0, 0));
        send_request(mk_req(KIND_FILTER, 31, 511, 1, COORD_MAX, COORD_MAX, COORD_MAX,
                            0, 0, 0));
        send_request(mk_req(KIND_FILTER, 47, 0, 1, 131070, 0, 0, 0, 0, 0));
        send_request(mk_req(KIND_FILTER, 40, 511, 0, 0, 0, 0, 0, 0, 0));

        load_phase(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX,
                   0, 16'hFF00);
        run_phase(PHASE_ITEMS, 1'b0, 1'b0);
        load_phase(5000, -5000, 2000, -3000, -1000, 1500, 3000, 16'hFF00);
        run_phase(PHASE_ITEMS, 1'b1, 1'b0);
        load_phase(0, 0, 0, 0, 0, 0, COORD_MAX, 16'hFFFF);
        run_phase(PHASE_ITEMS, 1'b0, 1'b0);
        load_phase(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, 0, 100, 1500, 16'h0000);
        run_phase(PHASE_ITEMS, 1'b0, 1'b0);
        load_phase(rand_coord(60000), rand_coord(60000), rand_coord(60000),
                   rand_coord(60000), rand_coord(60000), rand_coord(60000),
                   $urandom_range(0, 20000), $urandom_range(0, 65535));
        run_phase(PHASE_ITEMS, 1'b0, 1'b1);
        load_phase(-20000, 20000, -20000, 20000, -20000, 20000, 500, 16'h00FF);
        run_phase(PHASE_ITEMS, 1'b0, 1'b0);
        load_phase(4000, -4000, -6000, 6000, 3000, -3000, 2500, 16'h2010);
        run_phase(PHASE_ITEMS, 1'b0, 1'b0);
        load_phase(rand_coord(60000), rand_coord(60000), rand_coord(60000),
                   rand_coord(60000), rand_coord(60000), rand_coord(60000),
                   $urandom_range(0, COORD_MAX), $urandom_range(0, 65535));
        run_phase(PHASE_ITEMS, 1'b0, 1'b0);

        settle();
        if (board.mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire

@@ lidar_point_mask_filter.f @@
src/lpmf_pkg.sv
src/lpmf_range_sq.sv
src/lpmf_mask_mem.sv
src/lidar_point_mask_filter.sv
tb/lidar_point_mask_filter_test.sv
